// ----- design/scd_pkg.sv -----
package scd_pkg;

    localparam int ENTRIES_DEF     = 64;
    localparam int SECTOR_BITS_DEF = 32;
    localparam int OP_W            = 2;
    localparam int ENTRY_W         = 6;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_WB_READ,
        ST_ACC_DONE,
        ST_FL_SCAN,
        ST_FL_READ
    } scd_state_t;

endpackage

// ----- design/scd_tag_ram.sv -----
module scd_tag_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/sector_cache_clock_directory_unit.sv -----
// Access: a hit or a miss into a free entry takes the tag scan (one entry per cycle
// through the tag RAM read port); a full miss adds a clock sweep and one tag RAM
// read for a dirty victim. Hits exit the scan early. Flush: a scan of all entries
// plus one tag RAM read per dirty entry. One transaction in flight at a time.
// Reset clears valid, dirty and reference flags and the clock hand at once; the tag RAM
// is not cleared.
module sector_cache_clock_directory_unit #(
    parameter int ENTRIES     = scd_pkg::ENTRIES_DEF,
    parameter int SECTOR_BITS = scd_pkg::SECTOR_BITS_DEF,
    localparam int IN_W       = ((SECTOR_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((SECTOR_BITS + 9 + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_W-1:0]          s_tdata,   // sector
    input  logic [scd_pkg::OP_W-1:0] s_tuser,   // op
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_W-1:0]         m_tdata,   // hit, entry, writeback_needed,
                                                // writeback_sector, fill_needed
    output logic                     m_tlast
);

    import scd_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    scd_state_t state_reg, state_next;

    logic [OP_W-1:0]        op_reg, op_next;
    logic [SECTOR_BITS-1:0] sec_reg, sec_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IW-1:0]          chk_idx_reg, chk_idx_next;
    logic                   free_fnd_reg, free_fnd_next;
    logic [IW-1:0]          free_idx_reg, free_idx_next;
    logic [IW-1:0]          victim_reg, victim_next;
    logic                   hit_reg, hit_next;
    logic                   wb_reg, wb_next;
    logic [IW-1:0]          hand_reg, hand_next;
    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [ENTRIES-1:0]     dirty_reg, dirty_next;
    logic [ENTRIES-1:0]     ref_reg, ref_next;
    logic                   pend_vld_reg, pend_vld_next;
    logic [IW-1:0]          pend_idx_reg, pend_idx_next;
    logic [SECTOR_BITS-1:0] pend_sec_reg, pend_sec_next;

    logic                   out_vld_reg, out_vld_next;
    logic                   out_hit_reg, out_hit_next;
    logic [ENTRY_W-1:0]     out_entry_reg, out_entry_next;
    logic                   out_wb_reg, out_wb_next;
    logic [SECTOR_BITS-1:0] out_wsec_reg, out_wsec_next;
    logic                   out_fill_reg, out_fill_next;
    logic                   out_last_reg, out_last_next;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic [IW-1:0]          ram_raddr;
    logic [SECTOR_BITS-1:0] ram_rdata;

    logic                   out_free;
    logic                   in_xfer;

    scd_tag_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (SECTOR_BITS),
        .AW    (IW)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sec_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_W'({out_fill_reg, out_wsec_reg, out_wb_reg, out_entry_reg,
                              out_hit_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            chk_vld_reg  <= 1'b0;
            free_fnd_reg <= 1'b0;
            hand_reg     <= '0;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            ref_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            chk_vld_reg  <= chk_vld_next;
            free_fnd_reg <= free_fnd_next;
            hand_reg     <= hand_next;
            valid_reg    <= valid_next;
            dirty_reg    <= dirty_next;
            ref_reg      <= ref_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        sec_reg       <= sec_next;
        ptr_reg       <= ptr_next;
        chk_idx_reg   <= chk_idx_next;
        free_idx_reg  <= free_idx_next;
        victim_reg    <= victim_next;
        hit_reg       <= hit_next;
        wb_reg        <= wb_next;
        pend_idx_reg  <= pend_idx_next;
        pend_sec_reg  <= pend_sec_next;
        out_hit_reg   <= out_hit_next;
        out_entry_reg <= out_entry_next;
        out_wb_reg    <= out_wb_next;
        out_wsec_reg  <= out_wsec_next;
        out_fill_reg  <= out_fill_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        sec_next       = sec_reg;
        ptr_next       = ptr_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        free_fnd_next  = free_fnd_reg;
        free_idx_next  = free_idx_reg;
        victim_next    = victim_reg;
        hit_next       = hit_reg;
        wb_next        = wb_reg;
        hand_next      = hand_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        ref_next       = ref_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        pend_sec_next  = pend_sec_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_hit_next   = out_hit_reg;
        out_entry_next = out_entry_reg;
        out_wb_next    = out_wb_reg;
        out_wsec_next  = out_wsec_reg;
        out_fill_next  = out_fill_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = victim_reg;
        ram_raddr      = ptr_reg[IW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next       = s_tuser;
                    sec_next      = s_tdata[SECTOR_BITS-1:0];
                    ptr_next      = '0;
                    free_fnd_next = 1'b0;
                    hit_next      = 1'b0;
                    wb_next       = 1'b0;
                    case (s_tuser)
                        OP_READ, OP_WRITE: state_next = ST_SCAN;
                        OP_FLUSH:          state_next = ST_FL_SCAN;
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (ptr_reg < CW'(ENTRIES))
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = ptr_reg[IW-1:0];
                    ptr_next     = ptr_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (valid_reg[chk_idx_reg] && (ram_rdata == sec_reg))
                    begin
                        hit_next     = 1'b1;
                        victim_next  = chk_idx_reg;
                        chk_vld_next = 1'b0;
                        state_next   = ST_ACC_DONE;
                    end
                    else
                    begin
                        if (!valid_reg[chk_idx_reg] && !free_fnd_reg)
                        begin
                            free_fnd_next = 1'b1;
                            free_idx_next = chk_idx_reg;
                        end
                        if (chk_idx_reg == IW'(ENTRIES - 1))
                        begin
                            chk_vld_next = 1'b0;
                            if (free_fnd_reg)
                            begin
                                victim_next = free_idx_reg;
                                state_next  = ST_ACC_DONE;
                            end
                            else if (!valid_reg[chk_idx_reg])
                            begin
                                victim_next = chk_idx_reg;
                                state_next  = ST_ACC_DONE;
                            end
                            else
                            begin
                                state_next = ST_SWEEP;
                            end
                        end
                    end
                end
            end

            ST_SWEEP:
            begin
                if (ref_reg[hand_reg])
                begin
                    ref_next[hand_reg] = 1'b0;
                    if (hand_reg == IW'(ENTRIES - 1))
                    begin
                        hand_next = '0;
                    end
                    else
                    begin
                        hand_next = hand_reg + 1'b1;
                    end
                end
                else
                begin
                    victim_next = hand_reg;
                    if (dirty_reg[hand_reg])
                    begin
                        wb_next    = 1'b1;
                        state_next = ST_WB_READ;
                    end
                    else
                    begin
                        state_next = ST_ACC_DONE;
                    end
                end
            end

            ST_WB_READ:
            begin
                ram_raddr  = victim_reg;
                state_next = ST_ACC_DONE;
            end

            ST_ACC_DONE:
            begin
                ram_raddr = victim_reg;
                if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    out_hit_next   = hit_reg;
                    out_entry_next = ENTRY_W'(victim_reg);
                    out_wb_next    = wb_reg;
                    out_wsec_next  = wb_reg ? ram_rdata : '0;
                    out_fill_next  = !hit_reg;
                    out_last_next  = 1'b1;
                    ram_we         = !hit_reg;
                    valid_next[victim_reg] = 1'b1;
                    ref_next[victim_reg]   = 1'b1;
                    if (op_reg == OP_WRITE)
                    begin
                        dirty_next[victim_reg] = 1'b1;
                    end
                    else if (wb_reg)
                    begin
                        dirty_next[victim_reg] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_FL_SCAN:
            begin
                if (ptr_reg == CW'(ENTRIES))
                begin
                    if (!pend_vld_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_vld_next   = 1'b1;
                        out_hit_next   = 1'b0;
                        out_entry_next = ENTRY_W'(pend_idx_reg);
                        out_wb_next    = 1'b1;
                        out_wsec_next  = pend_sec_reg;
                        out_fill_next  = 1'b0;
                        out_last_next  = 1'b1;
                        pend_vld_next  = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else if (dirty_reg[ptr_reg[IW-1:0]])
                begin
                    state_next = ST_FL_READ;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            ST_FL_READ:
            begin
                if (!pend_vld_reg || out_free)
                begin
                    if (pend_vld_reg)
                    begin
                        out_vld_next   = 1'b1;
                        out_hit_next   = 1'b0;
                        out_entry_next = ENTRY_W'(pend_idx_reg);
                        out_wb_next    = 1'b1;
                        out_wsec_next  = pend_sec_reg;
                        out_fill_next  = 1'b0;
                        out_last_next  = 1'b0;
                    end
                    pend_vld_next = 1'b1;
                    pend_idx_next = ptr_reg[IW-1:0];
                    pend_sec_next = ram_rdata;
                    dirty_next[ptr_reg[IW-1:0]] = 1'b0;
                    ref_next[ptr_reg[IW-1:0]]   = 1'b0;
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_FL_SCAN;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
